[rtl/cftx_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// cftx_pkg
// Types and constants shared by the credit flow transmit segmenter modules.
// ---------------------------------------------------------------------------
package cftx_pkg;

   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned ReqDataWidth = 32;
   localparam int unsigned ReqUserWidth = 2;
   localparam int unsigned RspDataWidth = 104;

   localparam logic [15:0] SduLenFieldBytes = 16'd2;
   localparam logic [16:0] AclHeaderBytes   = 17'd4;
   localparam logic [16:0] H4HeaderBytes    = 17'd9;

   typedef enum logic [1:0] {
      ACTION_SEGMENT = 2'd0,
      ACTION_ADD_CREDITS = 2'd1,
      ACTION_CHECK_LENGTH = 2'd2,
      ACTION_UNKNOWN = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_UNAVAILABLE = 2'd1,
      STATUS_INVALID = 2'd2,
      STATUS_RESERVED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_MAX_SDU_SIZE = 3'd0,
      REG_MAX_PDU_PAYLOAD = 3'd1,
      REG_CONTROLLER_LIMIT = 3'd2,
      REG_REMOTE_CHANNEL = 3'd3,
      REG_LINK_HANDLE = 3'd4,
      REG_INITIAL_CREDITS = 3'd5,
      REG_SPARE_6 = 3'd6,
      REG_SPARE_7 = 3'd7
   } reg_index_type;

   typedef struct packed {
      action_type  action;
      logic [15:0] sdu_total;
      logic [15:0] credit_grant;
   } item_type;

   typedef struct packed {
      logic [15:0] max_sdu_size;
      logic [15:0] max_pdu_payload;
      logic [15:0] controller_payload_limit;
      logic        credit_load;
      logic [15:0] credit_load_value;
   } cfg_type;

   typedef struct packed {
      logic        credits_were_zero;
      logic        payload_done;
      logic [15:0] sdu_len_field;
      logic [16:0] h4_length;
      logic [16:0] acl_length;
      logic [15:0] kframe_len;
      logic [15:0] segment_bytes;
      logic [15:0] segment_offset;
      logic        first_frame;
      status_type  status;
   } result_type;

endpackage
`default_nettype wire

[rtl/cftx_csr.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// cftx_csr
// Configuration register file behind the APB-style port.
// ---------------------------------------------------------------------------
module cftx_csr
   import cftx_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [CsrDataWidth-1:0] csr_pwdata,
   output logic      [CsrDataWidth-1:0] csr_prdata,
   output logic                         csr_pready,
   output cfg_type                      cfg
);

   logic [15:0] max_sdu_size_ff, max_sdu_size_in;
   logic [15:0] max_pdu_payload_ff, max_pdu_payload_in;
   logic [15:0] ctrl_limit_ff, ctrl_limit_in;
   logic [15:0] remote_channel_ff, remote_channel_in;
   logic [11:0] link_handle_ff, link_handle_in;
   logic [15:0] init_credits_ff, init_credits_in;
   logic        write_en;
   reg_index_type index;

   assign index      = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      max_sdu_size_in    = max_sdu_size_ff;
      max_pdu_payload_in = max_pdu_payload_ff;
      ctrl_limit_in      = ctrl_limit_ff;
      remote_channel_in  = remote_channel_ff;
      link_handle_in     = link_handle_ff;
      init_credits_in    = init_credits_ff;
      if (write_en) begin
         case (index)
            REG_MAX_SDU_SIZE:     max_sdu_size_in    = csr_pwdata[15:0];
            REG_MAX_PDU_PAYLOAD:  max_pdu_payload_in = csr_pwdata[15:0];
            REG_CONTROLLER_LIMIT: ctrl_limit_in      = csr_pwdata[15:0];
            REG_REMOTE_CHANNEL:   remote_channel_in  = csr_pwdata[15:0];
            REG_LINK_HANDLE:      link_handle_in     = csr_pwdata[11:0];
            REG_INITIAL_CREDITS:  init_credits_in    = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_sdu_size_ff    <= '0;
         max_pdu_payload_ff <= '0;
         ctrl_limit_ff      <= '0;
         remote_channel_ff  <= '0;
         link_handle_ff     <= '0;
         init_credits_ff    <= '0;
      end else begin
         max_sdu_size_ff    <= max_sdu_size_in;
         max_pdu_payload_ff <= max_pdu_payload_in;
         ctrl_limit_ff      <= ctrl_limit_in;
         remote_channel_ff  <= remote_channel_in;
         link_handle_ff     <= link_handle_in;
         init_credits_ff    <= init_credits_in;
      end
   end

   always_comb begin
      case (index)
         REG_MAX_SDU_SIZE:     csr_prdata = {16'd0, max_sdu_size_ff};
         REG_MAX_PDU_PAYLOAD:  csr_prdata = {16'd0, max_pdu_payload_ff};
         REG_CONTROLLER_LIMIT: csr_prdata = {16'd0, ctrl_limit_ff};
         REG_REMOTE_CHANNEL:   csr_prdata = {16'd0, remote_channel_ff};
         REG_LINK_HANDLE:      csr_prdata = {20'd0, link_handle_ff};
         REG_INITIAL_CREDITS:  csr_prdata = {16'd0, init_credits_ff};
         default:              csr_prdata = '0;
      endcase
   end

   assign cfg.max_sdu_size             = max_sdu_size_ff;
   assign cfg.max_pdu_payload          = max_pdu_payload_ff;
   assign cfg.controller_payload_limit = ctrl_limit_ff;
   assign cfg.credit_load              = write_en && (index == REG_INITIAL_CREDITS);
   assign cfg.credit_load_value        = csr_pwdata[15:0];

endmodule
`default_nettype wire

[rtl/cftx_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// cftx_core
// Channel state (credits, SDU offset, continuation flag) and the single-pass
// evaluation of one action against it.
// ---------------------------------------------------------------------------
module cftx_core
   import cftx_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  step_en,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic [15:0] credit_ff, credit_in;
   logic [15:0] position_ff, position_in;
   logic        continuing_ff, continuing_in;

   logic [15:0] limit;
   logic        unavailable;
   logic        first;
   logic [15:0] first_cap;
   logic [15:0] remain;
   logic [15:0] seg;
   logic [15:0] pdu;
   logic [15:0] pos_next;
   logic        done;
   logic [16:0] credit_sum;

   always_comb begin
      limit = (cfg.controller_payload_limit > cfg.max_pdu_payload) ?
              cfg.max_pdu_payload : cfg.controller_payload_limit;
      unavailable = (credit_ff == 16'd0) || (cfg.controller_payload_limit == 16'd0) ||
                    (limit <= SduLenFieldBytes);
      first     = !continuing_ff;
      first_cap = limit - SduLenFieldBytes;
      remain    = (item.sdu_total >= position_ff) ? (item.sdu_total - position_ff) : 16'd0;
      if (first) begin
         seg = (item.sdu_total < first_cap) ? item.sdu_total : first_cap;
         pdu = seg + SduLenFieldBytes;
      end else begin
         seg = (remain < limit) ? remain : limit;
         pdu = seg;
      end
      pos_next   = position_ff + seg;
      done       = (pos_next == item.sdu_total);
      credit_sum = {1'b0, credit_ff} + {1'b0, item.credit_grant};
   end

   always_comb begin
      result        = '0;
      credit_in     = credit_ff;
      position_in   = position_ff;
      continuing_in = continuing_ff;
      case (item.action)
         ACTION_SEGMENT: begin
            if (unavailable) begin
               result.status = STATUS_UNAVAILABLE;
            end else begin
               result.status         = STATUS_OK;
               result.first_frame    = first;
               result.segment_offset = position_ff;
               result.segment_bytes  = seg;
               result.kframe_len     = pdu;
               result.acl_length     = {1'b0, pdu} + AclHeaderBytes;
               result.h4_length      = {1'b0, pdu} + H4HeaderBytes;
               result.sdu_len_field  = first ? item.sdu_total : 16'd0;
               result.payload_done   = done;
               position_in           = done ? 16'd0 : pos_next;
               continuing_in         = !done;
               credit_in             = credit_ff - 16'd1;
            end
         end
         ACTION_ADD_CREDITS: begin
            if (credit_sum[16]) begin
               result.status = STATUS_INVALID;
            end else begin
               result.credits_were_zero = (credit_ff == 16'd0);
               credit_in                = credit_sum[15:0];
            end
         end
         ACTION_CHECK_LENGTH: begin
            result.status = (item.sdu_total > cfg.max_sdu_size) ? STATUS_INVALID : STATUS_OK;
         end
         default: begin
            result.status = STATUS_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff     <= '0;
         position_ff   <= '0;
         continuing_ff <= 1'b0;
      end else if (cfg.credit_load) begin
         credit_ff <= cfg.credit_load_value;
      end else if (step_en) begin
         credit_ff     <= credit_in;
         position_ff   <= position_in;
         continuing_ff <= continuing_in;
      end
   end

endmodule
`default_nettype wire

[rtl/credit_flow_tx_segmenter.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// credit_flow_tx_segmenter
// Transmit-side segmenter for credit-based channel flow control.
// ---------------------------------------------------------------------------
// Each request transaction carries one action (segment, add credits, check
// length) and yields exactly one response transaction. A request is captured
// in an input register, evaluated combinationally against the channel state
// and written to the response register, so one transaction per cycle is
// sustained while the response side accepts; a stalled response holds the
// request in the input register. The core updates the channel state once per
// evaluated transaction. Configuration writes are meant for idle periods;
// writing the initial credit register also loads the live credit counter.
// ---------------------------------------------------------------------------
module credit_flow_tx_segmenter
   import cftx_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // tdata: sdu_total[15:0], credit_grant[31:16]
   input  wire logic [ReqDataWidth-1:0] req_tdata,
   // tuser: action[1:0]
   input  wire logic [ReqUserWidth-1:0] req_tuser,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // tdata: status[1:0], first_frame[2], segment_offset[18:3],
   // segment_bytes[34:19], kframe_len[50:35], acl_length[67:51],
   // h4_length[84:68], sdu_len_field[100:85], payload_done[101],
   // credits_were_zero[102], zero pad[103]
   output logic      [RspDataWidth-1:0] rsp_tdata,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [CsrDataWidth-1:0] csr_pwdata,
   output logic      [CsrDataWidth-1:0] csr_prdata,
   output logic                         csr_pready
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result;
   result_type result_ff;
   logic       result_valid_ff;
   logic       advance;

   cftx_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign advance    = item_valid_ff && (!result_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;

   cftx_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.action       <= action_type'(req_tuser);
         item_ff.sdu_total    <= req_tdata[15:0];
         item_ff.credit_grant <= req_tdata[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else if (advance) begin
         result_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         result_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = result_valid_ff;
   assign rsp_tdata  = {1'b0,
                        result_ff.credits_were_zero,
                        result_ff.payload_done,
                        result_ff.sdu_len_field,
                        result_ff.h4_length,
                        result_ff.acl_length,
                        result_ff.kframe_len,
                        result_ff.segment_bytes,
                        result_ff.segment_offset,
                        result_ff.first_frame,
                        result_ff.status};

endmodule
`default_nettype wire

[dv/tb_credit_flow_tx_segmenter.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_credit_flow_tx_segmenter
// Self-checking testbench for the credit flow transmit segmenter. A directed
// table covers reset state, field extremes and error codes, then mixed random
// traffic over several channel settings. Each response is compared field by
// field against a behavioral channel model or a directed row's fixed result.
// ---------------------------------------------------------------------------
module tb_credit_flow_tx_segmenter
   import cftx_pkg::*;
();

   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 8;
   localparam int LongHold    = 300;
   localparam logic [16:0] CreditCeiling = 17'd65535;
   localparam int FirstConfiguredRow = 9;
   localparam int RowCount = 24;

   typedef struct packed {
      action_type  action;
      logic [15:0] sdu_total;
      logic [15:0] credit_grant;
      logic        known;
      status_type  want_status;
      logic        want_credits_were_zero;
   } stim_row_type;

   localparam stim_row_type DirectedRows [RowCount] = '{
      '{ACTION_SEGMENT,      16'd100,   16'd0,     1'b1, STATUS_UNAVAILABLE, 1'b0},
      '{ACTION_CHECK_LENGTH, 16'd0,     16'd0,     1'b1, STATUS_OK,          1'b0},
      '{ACTION_CHECK_LENGTH, 16'd1,     16'd0,     1'b1, STATUS_INVALID,     1'b0},
      '{ACTION_CHECK_LENGTH, 16'd65535, 16'd0,     1'b1, STATUS_INVALID,     1'b0},
      '{ACTION_UNKNOWN,      16'd65535, 16'd65535, 1'b1, STATUS_INVALID,     1'b0},
      '{ACTION_ADD_CREDITS,  16'd0,     16'd0,     1'b1, STATUS_OK,          1'b1},
      '{ACTION_ADD_CREDITS,  16'd0,     16'd65535, 1'b1, STATUS_OK,          1'b1},
      '{ACTION_ADD_CREDITS,  16'd0,     16'd1,     1'b1, STATUS_INVALID,     1'b0},
      '{ACTION_SEGMENT,      16'd0,     16'd0,     1'b1, STATUS_UNAVAILABLE, 1'b0},
      '{ACTION_CHECK_LENGTH, 16'd1500,  16'd0,     1'b1, STATUS_OK,          1'b0},
      '{ACTION_CHECK_LENGTH, 16'd1501,  16'd0,     1'b1, STATUS_INVALID,     1'b0},
      '{ACTION_SEGMENT,      16'd50,    16'd0,     1'b0, STATUS_OK,          1'b0},
      '{ACTION_SEGMENT,      16'd50,    16'd0,     1'b0, STATUS_OK,          1'b0},
      '{ACTION_SEGMENT,      16'd10,    16'd0,     1'b0, STATUS_OK,          1'b0},
      '{ACTION_SEGMENT,      16'd50,    16'd0,     1'b0, STATUS_OK,          1'b0},
      '{ACTION_SEGMENT,      16'd5,     16'd0,     1'b1, STATUS_UNAVAILABLE, 1'b0},
      '{ACTION_ADD_CREDITS,  16'd0,     16'd3,     1'b1, STATUS_OK,          1'b1},
      '{ACTION_ADD_CREDITS,  16'd0,     16'd65533, 1'b1, STATUS_INVALID,     1'b0},
      '{ACTION_SEGMENT,      16'd0,     16'd0,     1'b0, STATUS_OK,          1'b0},
      '{ACTION_SEGMENT,      16'd21,    16'd0,     1'b0, STATUS_OK,          1'b0},
      '{ACTION_SEGMENT,      16'd65535, 16'd0,     1'b0, STATUS_OK,          1'b0},
      '{ACTION_ADD_CREDITS,  16'd0,     16'd65532, 1'b0, STATUS_OK,          1'b0},
      '{ACTION_SEGMENT,      16'd65535, 16'd0,     1'b0, STATUS_OK,          1'b0},
      '{ACTION_ADD_CREDITS,  16'd0,     16'd0,     1'b0, STATUS_OK,          1'b0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   // tdata: sdu_total[15:0], credit_grant[31:16]
   logic [ReqDataWidth-1:0] req_tdata = '0;
   // tuser: action[1:0]
   logic [ReqUserWidth-1:0] req_tuser = '0;
   logic                    req_tvalid = 1'b0;
   wire                     req_tready;
   // tdata: status, first_frame, segment_offset, segment_bytes, kframe_len,
   // acl_length, h4_length, sdu_len_field, payload_done, credits_were_zero
   wire [RspDataWidth-1:0]  rsp_tdata;
   wire                     rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   wire  [CsrDataWidth-1:0] csr_prdata;
   wire                     csr_pready;

   // side information traveling with the request transaction
   logic       req_known = 1'b0;
   result_type req_known_result = '0;

   // channel model state and register shadow
   logic [15:0] cfg_mtu = '0;
   logic [15:0] cfg_mps = '0;
   logic [15:0] cfg_ctrl_limit = '0;
   logic [15:0] chan_credits = '0;
   logic [15:0] sdu_cursor = '0;
   logic        mid_sdu = 1'b0;

   result_type pending_responses[$];
   int         mismatch_count = 0;
   int         response_count = 0;
   int         cycle_count = 0;
   int         sender_idle_pct = 0;
   int         rsp_idle_pct = 0;
   int         rsp_hold_left = 0;
   bit         rsp_hold_request = 1'b0;

   credit_flow_tx_segmenter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic result_type next_channel_response(item_type it);
      result_type  r;
      logic [15:0] lim;
      logic [15:0] seg;
      logic [15:0] remain;
      logic [16:0] pdu;
      r = '0;
      case (it.action)
         ACTION_SEGMENT: begin
            lim = (cfg_ctrl_limit > cfg_mps) ? cfg_mps : cfg_ctrl_limit;
            if (chan_credits == 16'd0 || cfg_ctrl_limit == 16'd0 || lim <= SduLenFieldBytes) begin
               r.status = STATUS_UNAVAILABLE;
            end else begin
               r.status = STATUS_OK;
               r.first_frame = !mid_sdu;
               r.segment_offset = sdu_cursor;
               if (!mid_sdu) begin
                  seg = (it.sdu_total < lim - SduLenFieldBytes) ? it.sdu_total
                                                                : lim - SduLenFieldBytes;
                  pdu = {1'b0, seg} + {1'b0, SduLenFieldBytes};
                  r.sdu_len_field = it.sdu_total;
               end else begin
                  remain = (it.sdu_total >= sdu_cursor) ? it.sdu_total - sdu_cursor : 16'd0;
                  seg = (remain < lim) ? remain : lim;
                  pdu = {1'b0, seg};
               end
               r.segment_bytes = seg;
               r.kframe_len = pdu[15:0];
               r.acl_length = pdu + AclHeaderBytes;
               r.h4_length = pdu + H4HeaderBytes;
               sdu_cursor = sdu_cursor + seg;
               if (sdu_cursor == it.sdu_total) begin
                  r.payload_done = 1'b1;
                  sdu_cursor = '0;
                  mid_sdu = 1'b0;
               end else begin
                  mid_sdu = 1'b1;
               end
               chan_credits = chan_credits - 16'd1;
            end
         end
         ACTION_ADD_CREDITS: begin
            if ({1'b0, chan_credits} + {1'b0, it.credit_grant} > CreditCeiling) begin
               r.status = STATUS_INVALID;
            end else begin
               r.status = STATUS_OK;
               r.credits_were_zero = (chan_credits == 16'd0);
               chan_credits = chan_credits + it.credit_grant;
            end
         end
         ACTION_CHECK_LENGTH: begin
            r.status = (it.sdu_total > cfg_mtu) ? STATUS_INVALID : STATUS_OK;
         end
         default: begin
            r.status = STATUS_INVALID;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [16:0] want, logic [16:0] got);
      $display("response %0d: %s expected %0d got %0d", response_count, what, want, got);
      mismatch_count++;
   endtask

   task automatic compare_response(result_type want, result_type got);
      if (got.status !== want.status)
         report_mismatch("status", 17'(want.status), 17'(got.status));
      if (got.first_frame !== want.first_frame)
         report_mismatch("first_frame", 17'(want.first_frame), 17'(got.first_frame));
      if (got.segment_offset !== want.segment_offset)
         report_mismatch("segment_offset", 17'(want.segment_offset),
                         17'(got.segment_offset));
      if (got.segment_bytes !== want.segment_bytes)
         report_mismatch("segment_bytes", 17'(want.segment_bytes), 17'(got.segment_bytes));
      if (got.kframe_len !== want.kframe_len)
         report_mismatch("kframe_len", 17'(want.kframe_len), 17'(got.kframe_len));
      if (got.acl_length !== want.acl_length)
         report_mismatch("acl_length", want.acl_length, got.acl_length);
      if (got.h4_length !== want.h4_length)
         report_mismatch("h4_length", want.h4_length, got.h4_length);
      if (got.sdu_len_field !== want.sdu_len_field)
         report_mismatch("sdu_len_field", 17'(want.sdu_len_field), 17'(got.sdu_len_field));
      if (got.payload_done !== want.payload_done)
         report_mismatch("payload_done", 17'(want.payload_done), 17'(got.payload_done));
      if (got.credits_were_zero !== want.credits_were_zero)
         report_mismatch("credits_were_zero", 17'(want.credits_were_zero),
                         17'(got.credits_were_zero));
   endtask

   // check responses first, then record the expectation of a new request
   always @(posedge clock) begin
      item_type   accepted;
      result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_responses.size() == 0) begin
               report_mismatch("response with nothing pending", 17'd0, 17'd1);
            end else begin
               compare_response(pending_responses.pop_front(),
                                result_type'(rsp_tdata[$bits(result_type)-1:0]));
            end
            response_count++;
         end
         if (req_tvalid && req_tready) begin
            accepted.action = action_type'(req_tuser);
            accepted.sdu_total = req_tdata[15:0];
            accepted.credit_grant = req_tdata[31:16];
            want = next_channel_response(accepted);
            pending_responses.push_back(req_known ? req_known_result : want);
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_hold_request) begin
         rsp_hold_left = LongHold;
         rsp_hold_request = 1'b0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic write_csr(reg_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_MAX_SDU_SIZE:     cfg_mtu = value[15:0];
         REG_MAX_PDU_PAYLOAD:  cfg_mps = value[15:0];
         REG_CONTROLLER_LIMIT: cfg_ctrl_limit = value[15:0];
         REG_INITIAL_CREDITS:  chan_credits = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure_channel(logic [15:0] mtu, logic [15:0] mps, logic [15:0] ctrl,
                                    logic [15:0] cid, logic [11:0] handle,
                                    logic [15:0] credits);
      write_csr(REG_MAX_SDU_SIZE,     {16'($urandom), mtu});
      write_csr(REG_MAX_PDU_PAYLOAD,  {16'($urandom), mps});
      write_csr(REG_CONTROLLER_LIMIT, {16'($urandom), ctrl});
      write_csr(REG_REMOTE_CHANNEL,   {16'($urandom), cid});
      write_csr(REG_LINK_HANDLE,      {20'($urandom), handle});
      write_csr(REG_INITIAL_CREDITS,  {16'($urandom), credits});
   endtask

   // drop valid, wait out every pending response, then let the pipeline settle
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic send_item(action_type act, logic [15:0] sdu, logic [15:0] grant,
                            logic known, status_type st, logic cwz);
      result_type fixed;
      fixed = '0;
      fixed.status = st;
      fixed.credits_were_zero = cwz;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {grant, sdu};
      req_known <= known;
      req_known_result <= fixed;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_mixed_traffic(int count);
      int          left;
      int          kind;
      int          run;
      int          lim;
      int          span;
      logic [15:0] sdu;
      logic [15:0] pick;
      left = count;
      while (left > 0) begin
         kind = $urandom_range(99);
         if (kind < 55) begin
            lim = int'((cfg_ctrl_limit > cfg_mps) ? cfg_mps : cfg_ctrl_limit);
            span = (lim < 3) ? 64 : ((lim * 4 > 65535) ? 65535 : lim * 4);
            sdu = ($urandom_range(99) < 85) ? 16'($urandom_range(0, span)) : 16'($urandom);
            run = $urandom_range(1, 5);
            for (int k = 0; k < run && left > 0; k++) begin
               // a shrunken length mid-SDU drops the remainder below the offset
               pick = ($urandom_range(99) < 10) ? 16'($urandom_range(0, sdu)) : sdu;
               send_item(ACTION_SEGMENT, pick, 16'($urandom), 1'b0, STATUS_OK, 1'b0);
               left--;
            end
         end else begin
            if (kind < 70) begin
               send_item(ACTION_ADD_CREDITS, 16'($urandom),
                         ($urandom_range(99) < 75) ? 16'($urandom_range(0, 8)) : 16'($urandom),
                         1'b0, STATUS_OK, 1'b0);
            end else if (kind < 82) begin
               send_item(ACTION_CHECK_LENGTH,
                         ($urandom_range(1) == 0) ? 16'(cfg_mtu + $urandom_range(0, 2) - 1)
                                                  : 16'($urandom),
                         16'($urandom), 1'b0, STATUS_OK, 1'b0);
            end else if (kind < 87) begin
               send_item(ACTION_UNKNOWN, 16'($urandom), 16'($urandom), 1'b0, STATUS_OK, 1'b0);
            end else begin
               send_item(action_type'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                         1'b0, STATUS_OK, 1'b0);
            end
            left--;
         end
      end
   endtask

   initial begin
      stim_row_type row;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_idle_pct = 15;
      rsp_idle_pct = 64;

      for (int n = 0; n < RowCount; n++) begin
         if (n == FirstConfiguredRow) begin
            drain_responses();
            configure_channel(16'd1500, 16'd23, 16'd27, 16'h0040, 12'habc, 16'd4);
         end
         row = DirectedRows[n];
         send_item(row.action, row.sdu_total, row.credit_grant, row.known,
                   row.want_status, row.want_credits_were_zero);
      end

      for (int phase = 0; phase < 6; phase++) begin
         drain_responses();
         case (phase)
            0: configure_channel(16'hffff, 16'hffff, 16'hffff, 16'hffff, 12'hfff, 16'hffff);
            1: begin
               configure_channel(16'd0, 16'd0, 16'd0, 16'd0, 12'd0, 16'd0);
               write_csr(REG_SPARE_6, $urandom);
               write_csr(REG_SPARE_7, $urandom);
            end
            default: begin
               configure_channel(16'($urandom),
                                 ($urandom_range(3) == 0) ? 16'($urandom_range(0, 4))
                                                          : 16'($urandom_range(3, 64)),
                                 ($urandom_range(4) == 0) ? 16'($urandom_range(0, 3))
                                                          : 16'($urandom_range(3, 80)),
                                 16'($urandom), 12'($urandom),
                                 ($urandom_range(3) == 0) ? 16'(65535 - $urandom_range(0, 20))
                                                          : 16'($urandom_range(0, 30)));
            end
         endcase
         if (phase < 2) begin
            sender_idle_pct = 15;
            rsp_idle_pct = 64;
         end else if (phase < 4) begin
            sender_idle_pct = 64;
            rsp_idle_pct = 15;
         end else begin
            sender_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         // stall the response side while requests keep coming
         if (phase == 4) rsp_hold_request = 1'b1;
         send_mixed_traffic(33);
         if (phase == 5) drain_responses();
         send_mixed_traffic(33);
      end

      drain_responses();
      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
